// File: hdl/bbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbb_pkg: shared types and constants of the bounded buffer broker
// field widths, reply codes, register indexes and controller/datapath links
// ----------------------------------------------------------------------------
package bbb_pkg;

    localparam int NODES_DEF      = 16;
    localparam int BUF_DEPTH_DEF  = 16;
    localparam int WAIT_DEPTH_DEF = 16;

    localparam int KIND_W  = 2;
    localparam int SRC_W   = 4;
    localparam int VAL_W   = 20;
    localparam int TAG_W   = 3;
    localparam int SUM_W   = 24;
    localparam int LIMIT_W = 5;
    localparam int TICK_W  = 32;
    localparam int WAIT_W  = SRC_W + VAL_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - (SRC_W + VAL_W + 1 + SUM_W);
    localparam int ADDR_W     = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 5'd2;
    localparam logic [TICK_W-1:0]  RUN_TICKS_RESET = 32'd1000;
    localparam logic [SUM_W-1:0]   SUM_MAX         = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_OFFER   = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_REPORT  = 2'd2,
        KIND_TICK    = 2'd3
    } kind_t;

    typedef enum logic [TAG_W-1:0] {
        TAG_NONE   = 3'd0,
        TAG_ACK    = 3'd1,
        TAG_ITEM   = 3'd2,
        TAG_EMPTY  = 3'd3,
        TAG_CANCEL = 3'd4
    } tag_t;

    typedef enum logic {
        REG_BUFFER_LIMIT = 1'b0,
        REG_RUN_TICKS    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [SRC_W-1:0] dest;
        tag_t             tag;
        logic [VAL_W-1:0] payload;
    } res_t;

    typedef struct packed {
        logic take;
        logic exec;
        logic rel;
        logic rel_slot;
        logic load_out;
        logic out_sel;
        logic out_none;
        logic out_last;
    } bbb_cmd_t;

    typedef struct packed {
        logic exec_emits;
        logic can_release;
    } bbb_sts_t;

endpackage

// File: hdl/bbb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbb_ctrl: broker sequencer
// steps one item through execute, release checks and result send-out
// ----------------------------------------------------------------------------
module bbb_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  bbb_pkg::bbb_sts_t sts,
    output bbb_pkg::bbb_cmd_t cmd
);
    import bbb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GAP,
        ST_CHECK,
        ST_SEND0,
        ST_SEND1
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] res_cnt_reg, res_cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_load;

    assign can_load = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.take     = s_tvalid && (state_reg == ST_IDLE);
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.rel      = (state_reg == ST_CHECK) && (res_cnt_reg < 2'd2) && sts.can_release;
        cmd.rel_slot = res_cnt_reg[0];
        cmd.load_out = ((state_reg == ST_SEND0) || (state_reg == ST_SEND1)) && can_load;
        cmd.out_sel  = (state_reg == ST_SEND1);
        cmd.out_none = (state_reg == ST_SEND0) && (res_cnt_reg == 2'd0);
        cmd.out_last = (state_reg == ST_SEND1) || (res_cnt_reg != 2'd2);
    end

    always_comb
    begin
        state_next   = state_reg;
        res_cnt_next = res_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.take)
                begin
                    state_next   = ST_EXEC;
                    res_cnt_next = 2'd0;
                end
            end
            ST_EXEC:
            begin
                res_cnt_next = {1'b0, sts.exec_emits};
                state_next   = ST_GAP;
            end
            ST_GAP:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (cmd.rel)
                begin
                    res_cnt_next = res_cnt_reg + 2'd1;
                    state_next   = ST_GAP;
                end
                else
                begin
                    state_next = ST_SEND0;
                end
            end
            ST_SEND0:
            begin
                if (can_load)
                begin
                    state_next = (res_cnt_reg == 2'd2) ? ST_SEND1 : ST_IDLE;
                end
            end
            ST_SEND1:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_cnt_reg   <= res_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a held result word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result word overwritten while held");

    // an accepted word goes straight to execute
    a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");

    // a result word stays offered until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result word dropped before it was taken");

endmodule

// File: hdl/bbb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbb_datapath: broker state and result path
// work fifo, deferred producer fifo, finished map, tick and consumed counters
// ----------------------------------------------------------------------------
module bbb_datapath
#(
    parameter int NODES      = bbb_pkg::NODES_DEF,
    parameter int BUF_DEPTH  = bbb_pkg::BUF_DEPTH_DEF,
    parameter int WAIT_DEPTH = bbb_pkg::WAIT_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bbb_pkg::bbb_cmd_t            cmd,
    output bbb_pkg::bbb_sts_t            sts,
    input  bbb_pkg::kind_t               in_kind,
    input  logic [bbb_pkg::SRC_W-1:0]    in_src,
    input  logic [bbb_pkg::VAL_W-1:0]    in_val,
    input  logic [bbb_pkg::LIMIT_W-1:0]  buffer_limit,
    input  logic [bbb_pkg::TICK_W-1:0]   run_ticks,
    output bbb_pkg::res_t                out_res,
    output logic                         out_last,
    output logic                         out_all_done,
    output logic [bbb_pkg::SUM_W-1:0]    out_total
);
    import bbb_pkg::*;

    localparam int BP = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int BC = $clog2(BUF_DEPTH + 1);
    localparam int WP = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WC = $clog2(WAIT_DEPTH + 1);
    localparam int FT = $clog2(NODES);

    // latched item
    kind_t            kind_reg;
    logic [SRC_W-1:0] src_reg;
    logic [VAL_W-1:0] val_reg;

    // work fifo
    logic [VAL_W-1:0] work_mem [BUF_DEPTH];
    logic [VAL_W-1:0] work_rd_reg;
    logic [BP-1:0]    work_head_reg, work_head_next;
    logic [BP-1:0]    work_tail_reg, work_tail_next;
    logic [BC-1:0]    work_count_reg, work_count_next;

    // deferred producer fifo
    logic [WAIT_W-1:0] wait_mem [WAIT_DEPTH];
    logic [WAIT_W-1:0] wait_rd_reg;
    logic [WP-1:0]     wait_head_reg, wait_head_next;
    logic [WP-1:0]     wait_tail_reg, wait_tail_next;
    logic [WC-1:0]     wait_count_reg, wait_count_next;

    logic [NODES-1:0]  finished_map_reg, finished_map_next;
    logic [FT-1:0]     finished_total_reg, finished_total_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [SUM_W-1:0]  consumed_sum_reg, consumed_sum_next;

    res_t slot_reg [2];

    logic             good_src;
    logic             expired;
    logic [31:0]      cap;
    logic             work_full;
    logic             wait_room;
    logic [NODES-1:0] src_onehot;
    logic             newly;
    logic [SUM_W:0]   sum_wide;
    logic             all_done;

    logic             do_tick, do_report, do_abort, do_push, do_defer, do_pop, emit;
    tag_t             emit_tag;
    logic [VAL_W-1:0] emit_payload;

    logic             work_wr_en, work_rd_en;
    logic [VAL_W-1:0] work_wr_data;
    logic             wait_wr_en;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            kind_reg <= in_kind;
            src_reg  <= in_src;
            val_reg  <= in_val;
        end
    end

    assign good_src  = (src_reg != '0) && (32'(src_reg) < NODES);
    assign expired   = (tick_count_reg >= run_ticks);
    assign wait_room = (32'(wait_count_reg) < WAIT_DEPTH);
    assign work_full = (32'(work_count_reg) >= cap);
    assign all_done  = (32'(finished_total_reg) >= NODES - 1);

    // capacity clamped to one .. BUF_DEPTH
    always_comb
    begin
        if (buffer_limit == '0)
        begin
            cap = 32'd1;
        end
        else if (32'(buffer_limit) > BUF_DEPTH)
        begin
            cap = BUF_DEPTH;
        end
        else
        begin
            cap = 32'(buffer_limit);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            src_onehot[i] = (32'(src_reg) == i);
        end
    end

    assign newly = ((finished_map_reg & src_onehot) == '0);

    // main action of one item
    always_comb
    begin
        do_tick      = 1'b0;
        do_report    = 1'b0;
        do_abort     = 1'b0;
        do_push      = 1'b0;
        do_defer     = 1'b0;
        do_pop       = 1'b0;
        emit         = 1'b0;
        emit_tag     = TAG_NONE;
        emit_payload = '0;
        if (kind_reg == KIND_TICK)
        begin
            do_tick = 1'b1;
        end
        else if (!good_src)
        begin
            emit = 1'b0;
        end
        else if (kind_reg == KIND_REPORT)
        begin
            do_report = 1'b1;
        end
        else if (expired)
        begin
            do_abort = 1'b1;
            emit     = 1'b1;
            emit_tag = TAG_CANCEL;
        end
        else if (kind_reg == KIND_OFFER)
        begin
            if (!work_full)
            begin
                do_push  = 1'b1;
                emit     = 1'b1;
                emit_tag = TAG_ACK;
            end
            else if (wait_room)
            begin
                do_defer = 1'b1;
            end
        end
        else
        begin
            emit = 1'b1;
            if (work_count_reg != '0)
            begin
                do_pop       = 1'b1;
                emit_tag     = TAG_ITEM;
                emit_payload = work_rd_reg;
            end
            else
            begin
                emit_tag = TAG_EMPTY;
            end
        end
    end

    assign sts.exec_emits  = emit;
    assign sts.can_release = (wait_count_reg != '0) && !work_full;

    assign work_wr_en   = (cmd.exec && do_push) || cmd.rel;
    assign work_wr_data = cmd.rel ? wait_rd_reg[VAL_W-1:0] : val_reg;
    assign work_rd_en   = cmd.exec && do_pop;
    assign wait_wr_en   = cmd.exec && do_defer;

    always_ff @(posedge clk)
    begin
        if (work_wr_en)
        begin
            work_mem[work_tail_reg] <= work_wr_data;
        end
        work_rd_reg <= work_mem[work_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wait_wr_en)
        begin
            wait_mem[wait_tail_reg] <= {src_reg, val_reg};
        end
        wait_rd_reg <= wait_mem[wait_head_reg];
    end

    always_comb
    begin
        work_head_next  = work_head_reg;
        work_tail_next  = work_tail_reg;
        work_count_next = work_count_reg;
        if (work_wr_en)
        begin
            work_tail_next  = (work_tail_reg == BP'(BUF_DEPTH - 1)) ? '0
                                                                    : work_tail_reg + 1'b1;
            work_count_next = work_count_reg + 1'b1;
        end
        else if (work_rd_en)
        begin
            work_head_next  = (work_head_reg == BP'(BUF_DEPTH - 1)) ? '0
                                                                    : work_head_reg + 1'b1;
            work_count_next = work_count_reg - 1'b1;
        end
    end

    always_comb
    begin
        wait_head_next  = wait_head_reg;
        wait_tail_next  = wait_tail_reg;
        wait_count_next = wait_count_reg;
        if (wait_wr_en)
        begin
            wait_tail_next  = (wait_tail_reg == WP'(WAIT_DEPTH - 1)) ? '0
                                                                     : wait_tail_reg + 1'b1;
            wait_count_next = wait_count_reg + 1'b1;
        end
        else if (cmd.rel)
        begin
            wait_head_next  = (wait_head_reg == WP'(WAIT_DEPTH - 1)) ? '0
                                                                     : wait_head_reg + 1'b1;
            wait_count_next = wait_count_reg - 1'b1;
        end
    end

    assign sum_wide = {1'b0, consumed_sum_reg} + (SUM_W + 1)'(val_reg);

    always_comb
    begin
        finished_map_next   = finished_map_reg;
        finished_total_next = finished_total_reg;
        tick_count_next     = tick_count_reg;
        consumed_sum_next   = consumed_sum_reg;
        if (cmd.exec)
        begin
            if ((do_report || do_abort) && newly)
            begin
                finished_map_next   = finished_map_reg | src_onehot;
                finished_total_next = finished_total_reg + 1'b1;
            end
            if (do_report)
            begin
                consumed_sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            end
            if (do_tick && (tick_count_reg != '1))
            begin
                tick_count_next = tick_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_head_reg      <= '0;
            work_tail_reg      <= '0;
            work_count_reg     <= '0;
            wait_head_reg      <= '0;
            wait_tail_reg      <= '0;
            wait_count_reg     <= '0;
            finished_map_reg   <= '0;
            finished_total_reg <= '0;
            tick_count_reg     <= '0;
            consumed_sum_reg   <= '0;
        end
        else
        begin
            work_head_reg      <= work_head_next;
            work_tail_reg      <= work_tail_next;
            work_count_reg     <= work_count_next;
            wait_head_reg      <= wait_head_next;
            wait_tail_reg      <= wait_tail_next;
            wait_count_reg     <= wait_count_next;
            finished_map_reg   <= finished_map_next;
            finished_total_reg <= finished_total_next;
            tick_count_reg     <= tick_count_next;
            consumed_sum_reg   <= consumed_sum_next;
        end
    end

    // result slots and output word
    always_ff @(posedge clk)
    begin
        if (cmd.exec && emit)
        begin
            slot_reg[0] <= '{dest: src_reg, tag: emit_tag, payload: emit_payload};
        end
        if (cmd.rel)
        begin
            slot_reg[cmd.rel_slot] <= '{dest: wait_rd_reg[WAIT_W-1:VAL_W], tag: TAG_ACK,
                                        payload: '0};
        end
        if (cmd.load_out)
        begin
            if (cmd.out_none)
            begin
                out_res <= '{dest: '0, tag: TAG_NONE, payload: '0};
            end
            else
            begin
                out_res <= slot_reg[cmd.out_sel];
            end
            out_last     <= cmd.out_last;
            out_all_done <= all_done;
            out_total    <= consumed_sum_reg;
        end
    end

    a_work_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(work_count_reg) <= BUF_DEPTH)
        else $error("work fifo count out of range");

    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wait_count_reg) <= WAIT_DEPTH)
        else $error("wait fifo count out of range");

    a_finished_sync: assert property (@(posedge clk) disable iff (!rst_n)
        32'(finished_total_reg) == $countones(finished_map_reg))
        else $error("finished total disagrees with finished map");

endmodule

// File: hdl/bounded_buffer_broker_unit.sv
`timescale 1ns / 1ps
// a taken input word passes execute, a read settle step and a release check before its
//   first result word is loaded, plus a settle and check per deferred producer released
// the one-item sequencer takes no new input word until its last result word is loaded,
//   and a load waits while the held output word is not taken (a second word adds a send)
// reset: rst_n asynchronous, clears fifo pointers, counters, finished map and
//   loads register defaults; fifo memories are not cleared (no clearing pass)
// ----------------------------------------------------------------------------
// bounded_buffer_broker_unit: producer/consumer broker top level
// apb register port, stream input of requests, stream output of replies
// ----------------------------------------------------------------------------
module bounded_buffer_broker_unit
#(
    parameter int NODES      = bbb_pkg::NODES_DEF,
    parameter int BUF_DEPTH  = bbb_pkg::BUF_DEPTH_DEF,
    parameter int WAIT_DEPTH = bbb_pkg::WAIT_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bbb_pkg::ADDR_W-1:0]        paddr,
    input  logic [bbb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bbb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bbb_pkg::IN_DATA_W-1:0]     s_tdata,   // source[3:0], value[23:4]
    input  logic [bbb_pkg::KIND_W-1:0]        s_tuser,   // req_type[1:0]
    // reply stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bbb_pkg::OUT_DATA_W-1:0]    m_tdata,   // dest[3:0], payload[23:4],
                                                         // all_done[24], consumed sum[48:25],
                                                         // zero[55:49]
    output logic [bbb_pkg::TAG_W-1:0]         m_tuser,   // reply_tag[2:0]
    output logic                              m_tlast
);
    import bbb_pkg::*;

    // configuration registers
    logic [LIMIT_W-1:0] buffer_limit_reg;
    logic [TICK_W-1:0]  run_ticks_reg;
    logic               cfg_write;
    reg_idx_t           cfg_idx;

    bbb_cmd_t           cmd;
    bbb_sts_t           sts;
    res_t               out_res;
    logic               out_last;
    logic               out_all_done;
    logic [SUM_W-1:0]   out_total;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[2]);
    // register lands on the access phase of the write
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_limit_reg <= LIMIT_RESET;
            run_ticks_reg    <= RUN_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_BUFFER_LIMIT: buffer_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_RUN_TICKS:    run_ticks_reg    <= pwdata[TICK_W-1:0];
                default:          buffer_limit_reg <= buffer_limit_reg;
            endcase
        end
    end

    // read-back, byte lanes above the register width read as zero
    always_comb
    begin
        case (cfg_idx)
            REG_BUFFER_LIMIT: prdata = APB_DATA_W'(buffer_limit_reg);
            REG_RUN_TICKS:    prdata = APB_DATA_W'(run_ticks_reg);
            default:          prdata = '0;
        endcase
    end

    // sequencer: takes one word, walks it through execute and up to two
    // releases, then hands the results to the output register
    bbb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // fifos, finished map, counters, result slots and output register
    bbb_datapath
    #(
        .NODES      (NODES),
        .BUF_DEPTH  (BUF_DEPTH),
        .WAIT_DEPTH (WAIT_DEPTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_kind      (kind_t'(s_tuser)),
        .in_src       (s_tdata[SRC_W-1:0]),
        .in_val       (s_tdata[SRC_W+VAL_W-1:SRC_W]),
        .buffer_limit (buffer_limit_reg),
        .run_ticks    (run_ticks_reg),
        .out_res      (out_res),
        .out_last     (out_last),
        .out_all_done (out_all_done),
        .out_total    (out_total)
    );

    // reply word packing, lowest field first
    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_total, out_all_done, out_res.payload,
                      out_res.dest};
    assign m_tuser = out_res.tag;
    assign m_tlast = out_last;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream-level test of the bounded buffer broker
// a scoreboard class keeps its own copy of the broker state (work fifo, wait
// list, finished map, tick count, consumed total) and predicts the reply words
// of every request word taken; replies are checked in order, field by field,
// across directed words, random phases at several capacity and run-time
// settings, a long output hold and mid-run drains
// ----------------------------------------------------------------------------
module tb;
    import bbb_pkg::*;

    localparam int STALL_LIMIT   = 4000;   // cycles without any transfer
    localparam int HOLD_CYCLES   = 300;    // long output back-pressure
    localparam int SETTLE_CYCLES = 24;     // covers two release steps and more
    localparam int MAX_REPORTS   = 10;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    // one reply word as seen on the output stream
    typedef struct {
        logic [SRC_W-1:0] dest;
        tag_t             tag;
        logic [VAL_W-1:0] payload;
        logic             last;
        logic             all_done;
        logic [SUM_W-1:0] total;
    } reply_t;

    // ------------------------------------------------------------------------
    // broker state copy and reply predictor
    // ------------------------------------------------------------------------
    class broker_scoreboard;
        logic [LIMIT_W-1:0]   limit;
        logic [TICK_W-1:0]    run_ticks;
        logic [VAL_W-1:0]     work_q[$];
        logic [WAIT_W-1:0]    wait_q[$];    // {source, value}
        logic [NODES_DEF-1:0] done_map;
        int unsigned          done_cnt;
        logic [TICK_W-1:0]    ticks;
        logic [SUM_W-1:0]     sum;
        reply_t               reply_q[$];
        int                   errors;

        function new();
            limit     = LIMIT_RESET;
            run_ticks = RUN_TICKS_RESET;
            done_map  = '0;
            done_cnt  = 0;
            ticks     = '0;
            sum       = '0;
            errors    = 0;
        endfunction

        function int unsigned capacity();
            if (limit == 0)
                return 1;
            if (limit > BUF_DEPTH_DEF)
                return BUF_DEPTH_DEF;
            return limit;
        endfunction

        function void mark_done(logic [SRC_W-1:0] node);
            if (!done_map[node])
            begin
                done_map[node] = 1'b1;
                done_cnt++;
            end
        endfunction

        function void mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s", $time, msg);
        endfunction

        function reply_t make_reply(logic [SRC_W-1:0] dest, tag_t tag,
                                    logic [VAL_W-1:0] payload);
            reply_t r;
            r.dest     = dest;
            r.tag      = tag;
            r.payload  = payload;
            r.last     = 1'b0;
            r.all_done = 1'b0;
            r.total    = '0;
            return r;
        endfunction

        function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
            if (idx == REG_BUFFER_LIMIT)
                limit = value[LIMIT_W-1:0];
            else
                run_ticks = value[TICK_W-1:0];
        endfunction

        // a request word was taken: work out its reply words
        function void note_request(kind_t kind, logic [SRC_W-1:0] src,
                                   logic [VAL_W-1:0] val);
            reply_t            step_q[$];
            logic [WAIT_W-1:0] held;
            logic [SUM_W:0]    acc;
            logic              expired;
            expired = ticks >= run_ticks;
            if (kind == KIND_TICK)
            begin
                if (ticks != '1)
                    ticks++;
            end
            else if (src == 0 || src >= NODES_DEF)
            begin
                // unknown sender, only pending releases happen
            end
            else if (kind == KIND_REPORT)
            begin
                mark_done(src);
                acc = sum + val;
                sum = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
            end
            else if (expired)
            begin
                step_q.push_back(make_reply(src, TAG_CANCEL, '0));
                mark_done(src);
            end
            else if (kind == KIND_OFFER)
            begin
                if (work_q.size() < capacity())
                begin
                    work_q.push_back(val);
                    step_q.push_back(make_reply(src, TAG_ACK, '0));
                end
                else if (wait_q.size() < WAIT_DEPTH_DEF)
                    wait_q.push_back({src, val});
            end
            else if (work_q.size() > 0)
                step_q.push_back(make_reply(src, TAG_ITEM, work_q.pop_front()));
            else
                step_q.push_back(make_reply(src, TAG_EMPTY, '0));

            // deferred producers move up while there is room, two words max
            while (step_q.size() < 2 && wait_q.size() > 0 && work_q.size() < capacity())
            begin
                held = wait_q.pop_front();
                work_q.push_back(held[VAL_W-1:0]);
                step_q.push_back(make_reply(held[WAIT_W-1:VAL_W], TAG_ACK, '0));
            end
            if (step_q.size() == 0)
                step_q.push_back(make_reply('0, TAG_NONE, '0));

            foreach (step_q[i])
            begin
                step_q[i].last     = (i == step_q.size() - 1);
                step_q[i].all_done = (done_cnt >= NODES_DEF - 1);
                step_q[i].total    = sum;
                reply_q.push_back(step_q[i]);
            end
        endfunction

        // a reply word was taken: compare with the oldest prediction
        function void check_reply(reply_t got);
            reply_t want;
            if (reply_q.size() == 0)
            begin
                mismatch($sformatf("unexpected reply dest=%0d tag=%0d payload=%h",
                                   got.dest, got.tag, got.payload));
                return;
            end
            want = reply_q.pop_front();
            if (got.dest !== want.dest || got.tag !== want.tag ||
                got.payload !== want.payload || got.last !== want.last ||
                got.all_done !== want.all_done || got.total !== want.total)
                mismatch($sformatf({"reply mismatch: exp dest=%0d tag=%0d payload=%h ",
                                    "last=%0b done=%0b total=%h / got dest=%0d tag=%0d ",
                                    "payload=%h last=%0b done=%0b total=%h"},
                                   want.dest, want.tag, want.payload, want.last,
                                   want.all_done, want.total, got.dest, got.tag,
                                   got.payload, got.last, got.all_done, got.total));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // source[3:0], value[23:4]
    logic [KIND_W-1:0]     s_tuser  = '0;   // req_type[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // dest, payload, all_done, consumed sum
    logic [TAG_W-1:0]      m_tuser;         // reply_tag[2:0]
    logic                  m_tlast;

    broker_scoreboard sb = new();

    // idle switches per side and the long-hold request to the receiver
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    bit hold_req  = 1'b0;
    int quiet_cycles = 0;

    bounded_buffer_broker_unit i_dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int next_gap(bit idle);
        return idle ? $urandom_range(0, 9) : 0;
    endfunction

    // ------------------------------------------------------------------------
    // reply side: random stalls, plus one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int stall;
        forever
        begin
            @(negedge clk);
            stall = next_gap(recv_idle);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // sample every reply word at the edge that takes it
    always @(posedge clk)
    begin : reply_monitor
        reply_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.dest     = m_tdata[SRC_W-1:0];
            got.payload  = m_tdata[SRC_W +: VAL_W];
            got.all_done = m_tdata[SRC_W + VAL_W];
            got.total    = m_tdata[SRC_W + VAL_W + 1 +: SUM_W];
            got.tag      = tag_t'(m_tuser);
            got.last     = m_tlast;
            sb.check_reply(got);
        end
    end

    // no transfer on any port for too long ends the run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // offer one request word; valid stays high into the next word when no gap
    task automatic send_word(kind_t kind, logic [SRC_W-1:0] src, logic [VAL_W-1:0] val);
        int gap;
        gap = next_gap(send_idle);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {val, src};
        do @(posedge clk); while (!s_tready);
        sb.note_request(kind, src, val);
    endtask

    // random word: kind by percentages, ticks take the rest
    task automatic send_random(int offer_pct, int req_pct, int report_pct);
        int               pick;
        kind_t            kind;
        logic [SRC_W-1:0] src;
        logic [VAL_W-1:0] val;
        pick = $urandom_range(0, 99);
        if (pick < offer_pct)
            kind = KIND_OFFER;
        else if (pick < offer_pct + req_pct)
            kind = KIND_REQUEST;
        else if (pick < offer_pct + req_pct + report_pct)
            kind = KIND_REPORT;
        else
            kind = KIND_TICK;
        // node 0 is no valid sender; it is sent now and then as a bad sender
        src = ($urandom_range(0, 39) == 0) ? '0 : SRC_W'($urandom_range(1, NODES_DEF - 1));
        case ($urandom_range(0, 7))
            0:       val = '0;
            1:       val = VAL_MAX;
            default: val = VAL_W'($urandom);
        endcase
        // keep most counts small so the total saturates late in the run
        if (kind == KIND_REPORT && $urandom_range(0, 3) != 0)
            val = val & VAL_W'(12'hFFF);
        send_word(kind, src, val);
    endtask

    task automatic run_phase(int words, int offer_pct, int req_pct, int report_pct);
        repeat (words) send_random(offer_pct, req_pct, report_pct);
    endtask

    // stop offering and wait until every predicted reply has been taken
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.reply_q.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write followed by a read back of the same register
    task automatic cfg_write(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        logic [APB_DATA_W-1:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        want = (idx == REG_BUFFER_LIMIT) ? APB_DATA_W'(sb.limit) : APB_DATA_W'(sb.run_ticks);
        if (readback !== want)
            sb.mismatch($sformatf("register %0d read %h, exp %h", idx, readback, want));
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words at reset settings (capacity 2, run time 1000)
        send_word(KIND_REQUEST, 4'd1,  '0);                 // empty fifo, empty reply
        send_word(KIND_OFFER,   4'd1,  '0);                 // ack
        send_word(KIND_OFFER,   4'd15, VAL_MAX);            // ack, fifo now full
        send_word(KIND_OFFER,   4'd2,  VAL_W'(20'h5A5A5));  // deferred, reply word with no tag
        send_word(KIND_OFFER,   4'd3,  VAL_W'(20'hA5A5A));  // deferred
        send_word(KIND_REQUEST, 4'd4,  '0);                 // work, then ack to node 2
        send_word(KIND_REQUEST, 4'd5,  VAL_MAX);            // work, then ack to node 3
        send_word(KIND_OFFER,   4'd0,  VAL_MAX);            // bad sender, ignored
        send_word(KIND_REQUEST, 4'd0,  '0);                 // bad sender, ignored
        send_word(KIND_REPORT,  4'd0,  VAL_MAX);            // bad sender, ignored
        send_word(KIND_REPORT,  4'd6,  VAL_MAX);            // finished, total grows
        send_word(KIND_REPORT,  4'd6,  VAL_W'(1));          // repeat finish, no recount
        send_word(KIND_TICK,    4'd0,  '0);
        send_word(KIND_TICK,    4'd15, VAL_MAX);
        send_word(KIND_REQUEST, 4'd7,  '0);                 // released value of node 2
        send_word(KIND_REQUEST, 4'd8,  '0);                 // released value of node 3
        send_word(KIND_REQUEST, 4'd9,  '0);                 // empty again
        drain();

        // smallest capacity, run never expires
        cfg_write(REG_BUFFER_LIMIT, 32'd1);
        cfg_write(REG_RUN_TICKS, 32'hFFFF_FFFF);
        run_phase(200, 40, 40, 8);
        drain();

        // full capacity at full rate; output held off while offers keep coming
        cfg_write(REG_BUFFER_LIMIT, 32'd16);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_req  = 1'b1;
        run_phase(60, 100, 0, 0);
        run_phase(140, 35, 45, 5);
        drain();

        // capacity 0 acts as 1; a flood of offers overruns the wait list
        send_idle = 1'b1;
        recv_idle = 1'b1;
        cfg_write(REG_BUFFER_LIMIT, 32'd0);
        run_phase(40, 100, 0, 0);
        run_phase(10, 0, 100, 0);
        run_phase(90, 40, 40, 8);
        drain();

        // capacity above depth acts as depth; leftover deferred words release
        cfg_write(REG_BUFFER_LIMIT, 32'd31);
        send_idle = 1'b0;
        recv_idle = 1'b1;
        run_phase(200, 40, 40, 8);
        drain();

        // capacity below the fill level; sender pauses mid-run until drained
        cfg_write(REG_BUFFER_LIMIT, 32'd3);
        send_idle = 1'b1;
        recv_idle = 1'b0;
        run_phase(100, 45, 35, 8);
        drain();
        run_phase(100, 35, 45, 8);
        drain();

        // run time runs out partway through, then everything aborts
        cfg_write(REG_BUFFER_LIMIT, 32'd5);
        cfg_write(REG_RUN_TICKS, sb.ticks + 32'd15);
        recv_idle = 1'b1;
        run_phase(150, 35, 35, 5);
        drain();

        // shortest run time, expired from the first word
        cfg_write(REG_RUN_TICKS, 32'd1);
        cfg_write(REG_BUFFER_LIMIT, 32'd2);
        run_phase(100, 40, 40, 8);
        drain();

        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
